### src/msp_pkg.sv
// msp_pkg: shared types and constants for the serial frame receiver
// no dependencies
package msp_pkg;

   // header characters
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_M = 8'h4D;
   localparam logic [7:0] CH_DIR_DEFAULT = 8'h3E;

   // configuration register indexes
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_LIMIT = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTION = 4'd1;
   localparam logic [6:0] SIZE_LIMIT_RESET = 7'd64;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_GOT_DOLLAR,
      PH_GOT_M,
      PH_SIZE,
      PH_CMD,
      PH_FILL,
      PH_CHECK
   } phase_type;

   // completed frame handed from parser to drain engine
   typedef struct packed {
      logic       bank;
      logic [7:0] command;
      logic [6:0] size;
   } desc_type;

   // payload bank given back by the drain engine
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   // one result word
   typedef struct packed {
      logic [7:0] command_id;
      logic [6:0] payload_size;
      logic [5:0] byte_index;
      logic [7:0] payload_byte;
      logic       has_byte;
      logic       last;
   } result_type;

endpackage

### src/msp_frame_receiver.sv
// msp_frame_receiver: top level of the serial frame receiver
// depends on msp_pkg, msp_ram, msp_front, msp_desc_fifo, msp_back
//
//  channel   ports                        direction  moves
//  ---------------------------------------------------------------------------
//  request   req_push / req_full          in         one received byte a word
//  response  rsp_pop / rsp_empty          out        one payload byte a word
//  csr       csr_valid / csr_ready        in         register index and data
//
// the parser takes one byte per cycle; it stalls only when the payload bank it
// must fill next still holds a checked frame that has not been drained
// each checked frame yields its result words from the payload ram, a read being
// issued only when the two-word result queue has room for it, counting a read
// still in flight; the first word passes the frame register, the registered ram
// read and the result queue before it shows
// reset is synchronous and clears control state only; no clearing pass, payload
// bytes come only from entries written for the same frame; csr_ready is always
// high; the user writes registers while idle, which the block does not enforce
module msp_frame_receiver
   import msp_pkg::*;
#(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   // received bytes
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [7:0]             req_rx_byte,
   // result words
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [7:0]             rsp_command_id,
   output logic [6:0]             rsp_payload_size,
   output logic [5:0]             rsp_byte_index,
   output logic [7:0]             rsp_payload_byte,
   output logic                   rsp_has_byte,
   output logic                   rsp_last,
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   // two payload banks so one frame can fill while the previous one drains
   localparam int RAM_DEPTH = 2 * MAX_PAYLOAD;
   localparam int AW = $clog2(RAM_DEPTH);

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic          ram_re;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;

   logic          desc_push;
   desc_type      desc_in_data;
   logic          desc_pop;
   logic          desc_valid;
   desc_type      desc_head;
   release_type   bank_release;
   result_type    rsp_word;

   assign csr_ready = 1'b1;

   // parser: header hunt, size check, payload fill, checksum
   msp_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD),
      .AW(AW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_rx_byte(req_rx_byte),
      .csr_we(csr_valid && csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .ram_we(ram_we),
      .ram_waddr(ram_waddr),
      .ram_wdata(ram_wdata),
      .desc_push(desc_push),
      .desc_data(desc_in_data),
      .bank_release(bank_release)
   );

   // payload store, both banks
   msp_ram #(
      .WIDTH(8),
      .DEPTH(RAM_DEPTH)
   ) u_ram (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en(ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // checked frames waiting for the drain engine
   msp_desc_fifo u_desc_fifo (
      .clock(clock),
      .reset(reset),
      .push(desc_push),
      .push_data(desc_in_data),
      .pop(desc_pop),
      .valid(desc_valid),
      .head_data(desc_head)
   );

   // drain engine and result queue
   msp_back #(
      .MAX_PAYLOAD(MAX_PAYLOAD),
      .AW(AW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .desc_valid(desc_valid),
      .desc_data(desc_head),
      .desc_pop(desc_pop),
      .ram_re(ram_re),
      .ram_raddr(ram_raddr),
      .ram_rdata(ram_rdata),
      .bank_release(bank_release),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_word(rsp_word)
   );

   assign rsp_command_id   = rsp_word.command_id;
   assign rsp_payload_size = rsp_word.payload_size;
   assign rsp_byte_index   = rsp_word.byte_index;
   assign rsp_payload_byte = rsp_word.payload_byte;
   assign rsp_has_byte     = rsp_word.has_byte;
   assign rsp_last         = rsp_word.last;

endmodule

### src/msp_ram.sv
// msp_ram: generic single-write, single-read ram with registered read data
// no dependencies
module msp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/msp_front.sv
// msp_front: header hunt, size check, payload fill into two banks, checksum
// depends on msp_pkg; writes payload through the ram ports of the top level
module msp_front
   import msp_pkg::*;
#(
   parameter int MAX_PAYLOAD = 64,
   parameter int AW = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [7:0]             req_rx_byte,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data,
   output logic                   ram_we,
   output logic [AW-1:0]          ram_waddr,
   output logic [7:0]             ram_wdata,
   output logic                   desc_push,
   output desc_type               desc_data,
   input  release_type            bank_release
);

   localparam logic [6:0] MAX_LIM = 7'(MAX_PAYLOAD);

   phase_type  phase_ff, phase_in;
   logic [6:0] size_ff, size_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [6:0] fill_ff, fill_in;
   logic [7:0] xor_ff, xor_in;
   logic       bank_ff, bank_in;
   logic [1:0] busy_ff, busy_in;
   logic [6:0] limit_ff, limit_in;
   logic [7:0] dir_ff, dir_in;

   logic [6:0] eff_limit;
   logic       accept;

   assign eff_limit = (limit_ff < MAX_LIM) ? limit_ff : MAX_LIM;
   // stall only while the bank to be written still holds an undrained frame
   assign req_full = busy_ff[bank_ff] && (phase_ff == PH_FILL || phase_ff == PH_CHECK);
   assign accept = req_push && !req_full;

   assign ram_wdata = req_rx_byte;
   assign ram_waddr = bank_ff ? (AW'(MAX_PAYLOAD) + AW'(fill_ff)) : AW'(fill_ff);
   assign desc_data = '{bank: bank_ff, command: cmd_ff, size: size_ff};

   always_comb begin
      phase_in  = phase_ff;
      size_in   = size_ff;
      cmd_in    = cmd_ff;
      fill_in   = fill_ff;
      xor_in    = xor_ff;
      bank_in   = bank_ff;
      busy_in   = busy_ff;
      limit_in  = limit_ff;
      dir_in    = dir_ff;
      ram_we    = 1'b0;
      desc_push = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_SIZE_LIMIT: limit_in = csr_data[6:0];
            CSR_DIRECTION:  dir_in = csr_data;
            default: ;
         endcase
      end

      if (bank_release.valid) begin
         busy_in[bank_release.bank] = 1'b0;
      end

      if (accept) begin
         case (phase_ff)
            PH_IDLE: begin
               phase_in = (req_rx_byte == CH_DOLLAR) ? PH_GOT_DOLLAR : PH_IDLE;
            end
            PH_GOT_DOLLAR: begin
               phase_in = (req_rx_byte == CH_M) ? PH_GOT_M : PH_IDLE;
            end
            PH_GOT_M: begin
               phase_in = (req_rx_byte == dir_ff) ? PH_SIZE : PH_IDLE;
            end
            PH_SIZE: begin
               if (req_rx_byte > {1'b0, eff_limit}) begin
                  phase_in = PH_IDLE;
               end else begin
                  size_in  = req_rx_byte[6:0];
                  xor_in   = req_rx_byte;
                  phase_in = PH_CMD;
               end
            end
            PH_CMD: begin
               cmd_in   = req_rx_byte;
               xor_in   = xor_ff ^ req_rx_byte;
               fill_in  = 7'd0;
               phase_in = (size_ff == 7'd0) ? PH_CHECK : PH_FILL;
            end
            PH_FILL: begin
               ram_we  = 1'b1;
               xor_in  = xor_ff ^ req_rx_byte;
               fill_in = fill_ff + 7'd1;
               if (fill_in >= size_ff) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               if (xor_ff == req_rx_byte) begin
                  desc_push        = 1'b1;
                  busy_in[bank_ff] = 1'b1;
                  bank_in          = ~bank_ff;
               end
               phase_in = PH_IDLE;
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         size_ff  <= 7'd0;
         cmd_ff   <= 8'd0;
         fill_ff  <= 7'd0;
         xor_ff   <= 8'd0;
         bank_ff  <= 1'b0;
         busy_ff  <= 2'b00;
         limit_ff <= SIZE_LIMIT_RESET;
         dir_ff   <= CH_DIR_DEFAULT;
      end else begin
         phase_ff <= phase_in;
         size_ff  <= size_in;
         cmd_ff   <= cmd_in;
         fill_ff  <= fill_in;
         xor_ff   <= xor_in;
         bank_ff  <= bank_in;
         busy_ff  <= busy_in;
         limit_ff <= limit_in;
         dir_ff   <= dir_in;
      end
   end

endmodule

### src/msp_desc_fifo.sv
// msp_desc_fifo: two-entry queue of completed frame descriptors
// depends on msp_pkg
module msp_desc_fifo
   import msp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_data,
   input  logic     pop,
   output logic     valid,
   output desc_type head_data
);

   desc_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign valid     = (count_ff != 2'd0);
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### src/msp_back.sv
// msp_back: drains one stored frame at a time into a two-word result queue
// depends on msp_pkg; reads payload through the ram ports of the top level
module msp_back
   import msp_pkg::*;
#(
   parameter int MAX_PAYLOAD = 64,
   parameter int AW = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        desc_valid,
   input  desc_type    desc_data,
   output logic        desc_pop,
   output logic        ram_re,
   output logic [AW-1:0] ram_raddr,
   input  logic [7:0]  ram_rdata,
   output release_type bank_release,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output result_type  rsp_word
);

   logic       active_ff, active_in;
   desc_type   cur_ff, cur_in;
   logic [6:0] k_ff, k_in;

   // word whose payload byte is being read this cycle
   logic       pend_ff, pend_in;
   result_type pend_word_ff, pend_word_in;

   result_type out_ff [2];
   logic       head_ff, head_in;
   logic       tail_ff, tail_in;
   logic [1:0] ocnt_ff, ocnt_in;

   logic       issue;
   logic       issue_last;
   logic       out_pop;
   result_type cap_word;

   assign out_pop   = rsp_pop && (ocnt_ff != 2'd0);
   assign rsp_empty = (ocnt_ff == 2'd0);
   assign rsp_word  = out_ff[head_ff];

   // only issue a read when the result queue has room for it
   assign issue      = active_ff && ((ocnt_ff + {1'b0, pend_ff}) < 2'd2);
   assign issue_last = (cur_ff.size == 7'd0) || ((k_ff + 7'd1) == cur_ff.size);
   assign ram_re     = issue;
   assign ram_raddr  = cur_ff.bank ? (AW'(MAX_PAYLOAD) + AW'(k_ff)) : AW'(k_ff);
   assign desc_pop   = !active_ff && desc_valid;
   assign bank_release = '{valid: issue && issue_last, bank: cur_ff.bank};

   always_comb begin
      cap_word = pend_word_ff;
      cap_word.payload_byte = pend_word_ff.has_byte ? ram_rdata : 8'd0;
   end

   always_comb begin
      active_in    = active_ff;
      cur_in       = cur_ff;
      k_in         = k_ff;
      pend_in      = issue;
      pend_word_in = pend_word_ff;

      if (desc_pop) begin
         cur_in    = desc_data;
         k_in      = 7'd0;
         active_in = 1'b1;
      end

      if (issue) begin
         pend_word_in.command_id   = cur_ff.command;
         pend_word_in.payload_size = cur_ff.size;
         pend_word_in.byte_index   = k_ff[5:0];
         pend_word_in.payload_byte = 8'd0;
         pend_word_in.has_byte     = (cur_ff.size != 7'd0);
         pend_word_in.last         = issue_last;
         k_in = k_ff + 7'd1;
         if (issue_last) begin
            active_in = 1'b0;
         end
      end

      head_in = out_pop ? ~head_ff : head_ff;
      tail_in = pend_ff ? ~tail_ff : tail_ff;
      ocnt_in = ocnt_ff + {1'b0, pend_ff} - {1'b0, out_pop};
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      k_ff         <= k_in;
      pend_word_ff <= pend_word_in;
      if (pend_ff) begin
         out_ff[tail_ff] <= cap_word;
      end
      if (reset) begin
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
         head_ff   <= 1'b0;
         tail_ff   <= 1'b0;
         ocnt_ff   <= 2'd0;
      end else begin
         active_ff <= active_in;
         pend_ff   <= pend_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         ocnt_ff   <= ocnt_in;
      end
   end

endmodule
